>>> hdl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine: list capacity,
// field widths, operation codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  // Number of entries the list can hold.
  localparam int CAPACITY = 16;

  // Entry address width into the entry store.
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Width of positions, lengths and counts on the channels.
  localparam int CNT_W = 5;

  // Width of one list entry.
  localparam int DATA_W = 32;

  // Width of the operation field.
  localparam int OP_W = 2;

  // Operation codes carried by a request transaction.
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2,
    OP_FIND   = 2'd3
  } ple_op_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_WR,
    S_INS_PUT,
    S_DEL_CAP,
    S_DEL_WR,
    S_GET_CAP,
    S_FIND,
    S_DONE
  } ple_state_e;

endpackage

`default_nettype wire

>>> hdl/ple_in_if.sv
// ----------------------------------------------------------------------------
// ple_in_if
// Request channel of the positional list engine: valid/ready handshake with
// the operation, the 1-based position and the value.
// ----------------------------------------------------------------------------
`default_nettype none

interface ple_in_if
  import ple_pkg::*;
();

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [CNT_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (
    output valid,
    output op,
    output position,
    output value,
    input  ready
  );

  modport sink (
    input  valid,
    input  op,
    input  position,
    input  value,
    output ready
  );

endinterface

`default_nettype wire

>>> hdl/ple_out_if.sv
// ----------------------------------------------------------------------------
// ple_out_if
// Response channel of the positional list engine: valid/ready handshake with
// the status, the returned entry, the find position and the list length.
// ----------------------------------------------------------------------------
`default_nettype none

interface ple_out_if
  import ple_pkg::*;
();

  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [DATA_W-1:0] data_out;
  logic [CNT_W-1:0]         found_at;
  logic [CNT_W-1:0]         count;

  modport source (
    output valid,
    output ok,
    output data_out,
    output found_at,
    output count,
    input  ready
  );

  modport sink (
    input  valid,
    input  ok,
    input  data_out,
    input  found_at,
    input  count,
    output ready
  );

endinterface

`default_nettype wire

>>> hdl/ple_ram.sv
// ----------------------------------------------------------------------------
// ple_ram
// Generic simple dual-port RAM: one write port and one read port with a
// registered read data output.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hdl/positional_list_engine_core.sv
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Fixed-capacity ordered list with insert, delete, get and find operations.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_i (op, 1-based position, value) and each one gives
//   exactly one response on rsp_o (ok, data_out, found_at, count).
//   The engine handles one request at a time; req_i.ready is high only while
//   the sequencer is idle. All entries live in one RAM with one write and one
//   registered read port, and each shift or search step moves one entry per
//   cycle through that port.
//   Insert shifts the entries from the tail down to the position, delete
//   from the position up to the tail, find reads from the head up to the
//   first match or the tail; get reads one entry and a failed request goes
//   straight to its response. req_i.ready rises again in the same cycle as
//   the response turns valid.
//   The response sits in an output register; while the receiver stalls the
//   engine still takes the next request and works it up to its result, then
//   waits until the output register is free.
//   Reset empties the list (length zero) and clears the handshake state.
//   Entry contents are not cleared; unwritten entries never reach a response.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine_core
  import ple_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ple_in_if.sink    req_i,
  ple_out_if.source rsp_o
);

  localparam logic [CNT_W-1:0] CapCnt = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] One    = CNT_W'(1);
  localparam logic [CNT_W-1:0] Two    = CNT_W'(2);

  ple_state_e state_q, state_d;

  logic [CNT_W-1:0]         len_q, len_d;
  logic [CNT_W-1:0]         pos_q, pos_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]         ptr_q, ptr_d;

  logic                     res_ok_q, res_ok_d;
  logic signed [DATA_W-1:0] res_data_q, res_data_d;
  logic [CNT_W-1:0]         res_found_q, res_found_d;
  logic [CNT_W-1:0]         res_count_q, res_count_d;

  logic                     out_valid_q, out_valid_d;
  logic                     out_ok_q, out_ok_d;
  logic signed [DATA_W-1:0] out_data_q, out_data_d;
  logic [CNT_W-1:0]         out_found_q, out_found_d;
  logic [CNT_W-1:0]         out_count_q, out_count_d;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  ple_op_e          op_in;
  logic [CNT_W-1:0] pos_in;
  logic             accept;
  logic             out_free;
  logic             ins_ok;
  logic             rd_ok;
  logic             find_hit;

  // Request decode and range checks.
  assign op_in    = ple_op_e'(req_i.op);
  assign pos_in   = req_i.position;
  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign ins_ok   = (pos_in != '0)
                 && ({1'b0, pos_in} <= ({1'b0, len_q} + (CNT_W+1)'(1)))
                 && (len_q < CapCnt);
  assign rd_ok    = (pos_in != '0) && (pos_in <= len_q);
  assign find_hit = (ram_rdata == DATA_W'(val_q));

  // Handshake outputs.
  assign req_i.ready    = (state_q == S_IDLE);
  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.ok       = out_ok_q;
  assign rsp_o.data_out = out_data_q;
  assign rsp_o.found_at = out_found_q;
  assign rsp_o.count    = out_count_q;

  // Entry store.
  ple_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY),
    .AW    (IDX_W)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op_in)
            OP_INSERT: begin
              if (!ins_ok) begin
                state_d = S_DONE;
              end else if (pos_in <= len_q) begin
                state_d = S_INS_WR;
              end else begin
                state_d = S_INS_PUT;
              end
            end
            OP_DELETE: state_d = rd_ok ? S_DEL_CAP : S_DONE;
            OP_GET:    state_d = rd_ok ? S_GET_CAP : S_DONE;
            OP_FIND:   state_d = (len_q != '0) ? S_FIND : S_DONE;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_INS_WR:  state_d = (ptr_q > pos_q) ? S_INS_WR : S_INS_PUT;
      S_INS_PUT: state_d = S_DONE;
      S_DEL_CAP: state_d = (ptr_q < len_q) ? S_DEL_WR : S_DONE;
      S_DEL_WR:  state_d = ((ptr_q + One) < len_q) ? S_DEL_WR : S_DONE;
      S_GET_CAP: state_d = S_DONE;
      S_FIND:    state_d = (find_hit || ((ptr_q + One) >= len_q)) ? S_DONE : S_FIND;
      S_DONE:    state_d = out_free ? S_IDLE : S_DONE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath control: RAM port, walk pointer, result and output registers.
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = IDX_W'(ptr_q);
    ram_wdata   = ram_rdata;
    ram_raddr   = '0;
    ptr_d       = ptr_q;
    pos_d       = pos_q;
    val_d       = val_q;
    len_d       = len_q;
    res_ok_d    = res_ok_q;
    res_data_d  = res_data_q;
    res_found_d = res_found_q;
    res_count_d = res_count_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_ok_d    = out_ok_q;
    out_data_d  = out_data_q;
    out_found_d = out_found_q;
    out_count_d = out_count_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          pos_d       = pos_in;
          val_d       = req_i.value;
          res_ok_d    = 1'b0;
          res_data_d  = '0;
          res_found_d = '0;
          res_count_d = len_q;
          unique case (op_in)
            OP_INSERT: begin
              if (ins_ok) begin
                // Walk down from the tail, reading the entry below the pointer.
                ptr_d       = len_q;
                ram_raddr   = IDX_W'(len_q - One);
                res_ok_d    = 1'b1;
                res_count_d = len_q + One;
              end
            end
            OP_DELETE: begin
              if (rd_ok) begin
                ptr_d       = pos_in;
                ram_raddr   = IDX_W'(pos_in - One);
                res_ok_d    = 1'b1;
                res_count_d = len_q - One;
              end
            end
            OP_GET: begin
              if (rd_ok) begin
                ram_raddr = IDX_W'(pos_in - One);
                res_ok_d  = 1'b1;
              end
            end
            OP_FIND: begin
              ptr_d     = '0;
              ram_raddr = '0;
              res_ok_d  = 1'b1;
            end
            default: begin
              res_ok_d = 1'b0;
            end
          endcase
        end
      end
      S_INS_WR: begin
        // Move one entry up and fetch the next one below.
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(ptr_q);
        ram_wdata = ram_rdata;
        ram_raddr = IDX_W'(ptr_q - Two);
        ptr_d     = ptr_q - One;
      end
      S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(pos_q - One);
        ram_wdata = DATA_W'(val_q);
      end
      S_DEL_CAP: begin
        // Keep the removed entry and fetch the first one to move down.
        res_data_d = ram_rdata;
        ram_raddr  = IDX_W'(ptr_q);
      end
      S_DEL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(ptr_q - One);
        ram_wdata = ram_rdata;
        ram_raddr = IDX_W'(ptr_q + One);
        ptr_d     = ptr_q + One;
      end
      S_GET_CAP: begin
        res_data_d = ram_rdata;
      end
      S_FIND: begin
        // Compare the entry at the pointer and fetch the next one.
        if (find_hit) begin
          res_found_d = ptr_q + One;
        end
        ram_raddr = IDX_W'(ptr_q + One);
        ptr_d     = ptr_q + One;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_ok_d    = res_ok_q;
          out_data_d  = res_data_q;
          out_found_d = res_found_q;
          out_count_d = res_count_q;
          len_d       = res_count_q;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    val_q       <= val_d;
    ptr_q       <= ptr_d;
    res_ok_q    <= res_ok_d;
    res_data_q  <= res_data_d;
    res_found_q <= res_found_d;
    res_count_q <= res_count_d;
    out_ok_q    <= out_ok_d;
    out_data_q  <= out_data_d;
    out_found_q <= out_found_d;
    out_count_q <= out_count_d;
  end

`ifndef SYNTH
  // The list never grows past its capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) len_q <= CapCnt)
    else $error("list length exceeds capacity");

  // A pending response always reports the current list length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_count_q == len_q))
    else $error("response count differs from list length");

  // A failed request returns no data and no position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ok_q) |-> ((out_data_q == '0) && (out_found_q == '0)))
    else $error("failed request carries data");

  // A find position never lies beyond the list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_found_q <= out_count_q))
    else $error("find position beyond list length");

  // The length moves by at most one per request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != $past(len_q)) |->
      ((len_q == ($past(len_q) + One)) || ((len_q + One) == $past(len_q))))
    else $error("list length jumped");
`endif

endmodule

`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for positional_list_engine_core. A shadow copy of the
// list predicts every response from the accepted requests. Directed requests
// cover the empty list, the range limits of positions, value extremes and
// first-match search, then random grow, shrink and mixed phases fill and drain
// the list, with random gaps on the request side and random stalls on the
// response side.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import ple_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_REQS = 900;
  localparam int SETTLE_CYCLES = CAPACITY + 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  // One response as the engine reports it.
  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] data_out;
    logic [CNT_W-1:0]  found_at;
    logic [CNT_W-1:0]  count;
  } list_rsp_t;

  // Shadow of the list contents that predicts and checks responses.
  class list_tracker;
    bit [DATA_W-1:0] slots[CAPACITY];
    int              length;
    list_rsp_t       expected_rsp[$];
    int              errors;
    int              checked;
    int              op_count[4];
    int              full_rejects;

    function new();
      length = 0;
      errors = 0;
      checked = 0;
      full_rejects = 0;
      foreach (op_count[k]) op_count[k] = 0;
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction

    // Apply one accepted request to the shadow list and queue its response.
    function void note_request(ple_op_e op, logic [CNT_W-1:0] pos, logic [DATA_W-1:0] val);
      list_rsp_t r;
      int        p;
      int        j;
      r = '0;
      p = int'(pos);
      op_count[op]++;
      case (op)
        OP_INSERT: begin
          if (length >= CAPACITY && p >= 1 && p <= length + 1) full_rejects++;
          if (p >= 1 && p <= length + 1 && length < CAPACITY) begin
            for (j = length; j >= p; j--) slots[j] = slots[j-1];
            slots[p-1] = val;
            length++;
            r.ok = 1'b1;
          end
        end
        OP_DELETE: begin
          if (p >= 1 && p <= length) begin
            r.data_out = slots[p-1];
            for (j = p; j < length; j++) slots[j-1] = slots[j];
            length--;
            r.ok = 1'b1;
          end
        end
        OP_GET: begin
          if (p >= 1 && p <= length) begin
            r.data_out = slots[p-1];
            r.ok = 1'b1;
          end
        end
        default: begin
          // Search stops at the first matching entry.
          r.ok = 1'b1;
          for (j = 0; j < length; j++) begin
            if (r.found_at == 0 && slots[j] == val) r.found_at = CNT_W'(j + 1);
          end
        end
      endcase
      r.count = CNT_W'(length);
      expected_rsp.push_back(r);
    endfunction

    // Compare one accepted response with the oldest prediction.
    function void check_response(list_rsp_t got);
      list_rsp_t want;
      if (expected_rsp.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: response with nothing outstanding: ok=%0b data=%h found=%0d count=%0d",
                   got.ok, got.data_out, got.found_at, got.count);
        return;
      end
      want = expected_rsp.pop_front();
      checked++;
      if (got.ok !== want.ok || got.data_out !== want.data_out ||
          got.found_at !== want.found_at || got.count !== want.count) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: response %0d: ok %0b/%0b data %h/%h found %0d/%0d count %0d/%0d %s",
                   checked, want.ok, got.ok, want.data_out, got.data_out,
                   want.found_at, got.found_at, want.count, got.count,
                   "(expected/actual)");
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   steady_tx;
  bit   steady_rx;
  int   cycles;

  list_tracker tracker;

  ple_in_if  req_if ();
  ple_out_if rsp_if ();

  positional_list_engine_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Clock generation.
  initial clk_i = 1'b0;
  always #(CLK_HALF) clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d responses outstanding.",
               cycles, tracker.pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Present one request and hold it until the engine takes it.
  task automatic send_request(ple_op_e op, logic [CNT_W-1:0] pos, logic [DATA_W-1:0] val);
    int gap;
    gap = steady_tx ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.op       <= op;
    req_if.position <= pos;
    req_if.value    <= val;
    do @(posedge clk_i); while (!req_if.ready);
    tracker.note_request(op, pos, val);
  endtask

  // Hold the request side off until every outstanding response has come back.
  task automatic drain_responses();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  // Operation mix: grow phases favor inserts, shrink phases favor deletes.
  function automatic ple_op_e pick_op(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0) begin
      if (r < 55) return OP_INSERT;
      if (r < 65) return OP_DELETE;
      if (r < 80) return OP_GET;
      return OP_FIND;
    end
    if (mode == 1) begin
      if (r < 15) return OP_INSERT;
      if (r < 65) return OP_DELETE;
      if (r < 80) return OP_GET;
      return OP_FIND;
    end
    return ple_op_e'(r % 4);
  endfunction

  // Mostly positions inside the legal range, sometimes anything the field holds.
  function automatic logic [CNT_W-1:0] pick_pos(ple_op_e op, int len);
    if ($urandom_range(0, 9) == 0) return CNT_W'($urandom_range(0, 31));
    case (op)
      OP_INSERT: return CNT_W'($urandom_range(1, len + 1));
      OP_DELETE,
      OP_GET:    return (len == 0) ? CNT_W'($urandom_range(0, 2))
                                   : CNT_W'($urandom_range(1, len));
      default:   return CNT_W'($urandom_range(0, 31));
    endcase
  endfunction

  // Values from a small pool give duplicates, so searches see several matches.
  function automatic logic [DATA_W-1:0] pick_value(ple_op_e op, int len);
    if (op == OP_FIND && len > 0 && $urandom_range(0, 1) == 1)
      return tracker.slots[$urandom_range(0, len - 1)];
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3:    return DATA_W'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  // Response side: random stall, then accept and check one transaction.
  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      stall = steady_rx ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
      tracker.check_response('{rsp_if.ok, rsp_if.data_out, rsp_if.found_at, rsp_if.count});
    end
  end

  // Main sequence: reset, directed requests, random phases, final check.
  initial begin
    int      i;
    int      mode;
    ple_op_e op;

    tracker = new();
    cycles = 0;
    steady_tx = 1'b0;
    steady_rx = 1'b0;
    rst_ni          <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.op       <= OP_INSERT;
    req_if.position <= '0;
    req_if.value    <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Everything on the empty list fails, and a search finds nothing.
    send_request(OP_GET,    5'd1, 32'h0);
    send_request(OP_DELETE, 5'd0, 32'h0);
    send_request(OP_DELETE, 5'd1, 32'h0);
    send_request(OP_FIND,   5'd0, 32'h0);
    send_request(OP_INSERT, 5'd0, 32'h1);
    send_request(OP_INSERT, 5'd2, 32'h1);
    // Build the list at front, middle and end with value extremes.
    send_request(OP_INSERT, 5'd1, 32'h8000_0000);
    send_request(OP_INSERT, 5'd2, 32'h7fff_ffff);
    send_request(OP_INSERT, 5'd1, 32'hffff_ffff);
    send_request(OP_INSERT, 5'd2, 32'h0);
    send_request(OP_INSERT, 5'd6, 32'h2);
    send_request(OP_INSERT, 5'd31, 32'h3);
    send_request(OP_GET,    5'd4, 32'h0);
    send_request(OP_GET,    5'd5, 32'h0);
    send_request(OP_GET,    5'd0, 32'h0);
    send_request(OP_FIND,   5'd0, 32'h8000_0000);
    send_request(OP_FIND,   5'd31, 32'h1234_5678);
    // A duplicate at the end; the search must report the first copy.
    send_request(OP_INSERT, 5'd5, 32'h0);
    send_request(OP_FIND,   5'd0, 32'h0);
    send_request(OP_DELETE, 5'd6, 32'h0);
    send_request(OP_DELETE, 5'd2, 32'h0);
    send_request(OP_DELETE, 5'd1, 32'h0);
    send_request(OP_DELETE, 5'd3, 32'h0);
    send_request(OP_GET,    5'd16, 32'h0);
    drain_responses();

    // Random phases; the first one favors inserts to grow the list.
    mode = 0;
    for (i = 0; i < RANDOM_REQS; i++) begin
      if (i % 40 == 0 && i > 0) mode = $urandom_range(0, 2);
      if (i % 60 == 0) begin
        steady_tx = ($urandom_range(0, 3) == 0);
        steady_rx = ($urandom_range(0, 3) == 0);
      end
      if (i % 150 == 149) drain_responses();
      op = pick_op(mode);
      send_request(op, pick_pos(op, tracker.length), pick_value(op, tracker.length));
    end

    // Let the last responses drain, then give the engine time to misbehave.
    drain_responses();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (tracker.pending() != 0) tracker.errors++;
    $display("Checked %0d responses: %0d inserts, %0d deletes, %0d gets, %0d finds.",
             tracker.checked, tracker.op_count[OP_INSERT], tracker.op_count[OP_DELETE],
             tracker.op_count[OP_GET], tracker.op_count[OP_FIND]);
    $display("Inserts refused on a full list: %0d; mismatches: %0d.",
             tracker.full_rejects, tracker.errors);
    if (tracker.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
hdl/ple_pkg.sv
hdl/ple_in_if.sv
hdl/ple_out_if.sv
hdl/ple_ram.sv
hdl/positional_list_engine_core.sv
test/testbench.sv
